// File: hdl/trsm_pkg.sv
`default_nettype none

package trsm_pkg;

   // Burst length default and its legal ceiling (the data ports are eight bytes wide).
   localparam int unsigned BurstBytesDefault = 8;
   localparam int unsigned MaxBurstBytes     = 8;

   // Request command codes. Codes 5..7 are treated as a plain tick.
   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_SREAD  = 3'd1;
   localparam logic [2:0] CMD_SWRITE = 3'd2;
   localparam logic [2:0] CMD_BREAD  = 3'd3;
   localparam logic [2:0] CMD_BWRITE = 3'd4;

   // Clock burst command bytes.
   localparam logic [7:0] BURST_READ_CMD  = 8'hBF;
   localparam logic [7:0] BURST_WRITE_CMD = 8'hBE;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SET,
      PH_HIGH,
      PH_LOW,
      PH_RHIGH,
      PH_RLOW,
      PH_STOP
   } phase_type;

   // One result beat as produced by the link engine.
   typedef struct packed {
      logic        chip_enable;
      logic        serial_clock;
      logic        io_out;
      logic        io_drive;
      logic        busy;
      logic        done;
      logic [63:0] read_bytes;
   } tick_result_type;

endpackage

`default_nettype wire

// File: hdl/trsm_engine.sv
`default_nettype none

module trsm_engine #(
   parameter int unsigned BURST_BYTES = trsm_pkg::BurstBytesDefault
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [2:0]             cmd,
   input  wire logic [7:0]             reg_address,
   input  wire logic [63:0]            write_bytes,
   input  wire logic                   io_in,
   output trsm_pkg::tick_result_type   result
);
   import trsm_pkg::*;

   localparam int unsigned DataWidth = BURST_BYTES * 8;
   localparam int unsigned PosWidth  = $clog2(DataWidth);

   phase_type              phase_ff, phase_in;
   logic [2:0]             bit_count_ff, bit_count_in;
   logic [3:0]             byte_count_ff, byte_count_in;
   logic [2:0]             operation_ff, operation_in;
   logic [DataWidth-1:0]   tx_shift_ff, tx_shift_in;
   logic [7:0]             command_byte_ff, command_byte_in;
   logic [DataWidth-1:0]   rx_shift_ff, rx_shift_in;
   logic                   ce_ff, ce_in;
   logic                   clk_ff, clk_in;
   logic                   io_ff, io_in_next;
   logic                   drive_ff, drive_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [PosWidth-1:0]    pend_pos_ff, pend_pos_in;

   logic                   is_read;
   logic                   is_burst;
   logic [3:0]             data_bytes;
   logic [3:0]             byte_m1;
   logic [PosWidth-1:0]    tx_pos;
   logic [3:0]             byte_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         bit_count_ff    <= '0;
         byte_count_ff   <= '0;
         operation_ff    <= '0;
         tx_shift_ff     <= '0;
         command_byte_ff <= '0;
         rx_shift_ff     <= '0;
         ce_ff           <= 1'b0;
         clk_ff          <= 1'b0;
         io_ff           <= 1'b0;
         drive_ff        <= 1'b0;
         pend_valid_ff   <= 1'b0;
         pend_pos_ff     <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         bit_count_ff    <= bit_count_in;
         byte_count_ff   <= byte_count_in;
         operation_ff    <= operation_in;
         tx_shift_ff     <= tx_shift_in;
         command_byte_ff <= command_byte_in;
         rx_shift_ff     <= rx_shift_in;
         ce_ff           <= ce_in;
         clk_ff          <= clk_in;
         io_ff           <= io_in_next;
         drive_ff        <= drive_in;
         pend_valid_ff   <= pend_valid_in;
         pend_pos_ff     <= pend_pos_in;
      end
   end

   assign is_read    = (operation_ff == CMD_SREAD) || (operation_ff == CMD_BREAD);
   assign is_burst   = (operation_ff == CMD_BREAD) || (operation_ff == CMD_BWRITE);
   assign data_bytes = is_burst ? 4'(BURST_BYTES) : 4'd1;
   assign byte_m1    = byte_count_ff - 4'd1;
   assign tx_pos     = PosWidth'({byte_m1, bit_count_ff});
   assign byte_inc   = byte_count_ff + 4'd1;

   always_comb begin
      phase_in        = phase_ff;
      bit_count_in    = bit_count_ff;
      byte_count_in   = byte_count_ff;
      operation_in    = operation_ff;
      tx_shift_in     = tx_shift_ff;
      command_byte_in = command_byte_ff;
      rx_shift_in     = rx_shift_ff;
      ce_in           = ce_ff;
      clk_in          = clk_ff;
      io_in_next      = io_ff;
      drive_in        = drive_ff;
      pend_valid_in   = pend_valid_ff;
      pend_pos_in     = pend_pos_ff;
      result.busy       = (phase_ff != PH_IDLE);
      result.done       = 1'b0;
      result.read_bytes = '0;

      // A bit sampled on the tick after the clock fell.
      if ((phase_ff == PH_RHIGH || phase_ff == PH_STOP) && pend_valid_ff) begin
         if (io_in) begin
            rx_shift_in[pend_pos_ff] = 1'b1;
         end
         pend_valid_in = 1'b0;
      end

      case (phase_ff)
         PH_IDLE: begin
            if (cmd >= CMD_SREAD && cmd <= CMD_BWRITE) begin
               operation_in = cmd;
               case (cmd)
                  CMD_SREAD:  command_byte_in = reg_address | 8'h01;
                  CMD_SWRITE: command_byte_in = reg_address & 8'hFE;
                  CMD_BREAD:  command_byte_in = BURST_READ_CMD;
                  default:    command_byte_in = BURST_WRITE_CMD;
               endcase
               tx_shift_in   = (cmd == CMD_SWRITE)
                             ? DataWidth'(write_bytes[7:0])
                             : write_bytes[DataWidth-1:0];
               rx_shift_in   = '0;
               bit_count_in  = '0;
               byte_count_in = '0;
               pend_valid_in = 1'b0;
               ce_in         = 1'b1;
               clk_in        = 1'b0;
               drive_in      = 1'b1;
               phase_in      = PH_SET;
               result.busy   = 1'b1;
            end
         end
         PH_SET: begin
            if (byte_count_ff == 4'd0) begin
               io_in_next = command_byte_ff[bit_count_ff];
            end else begin
               io_in_next = tx_shift_ff[tx_pos];
            end
            phase_in = PH_HIGH;
         end
         PH_HIGH: begin
            clk_in   = 1'b1;
            phase_in = PH_LOW;
         end
         PH_LOW: begin
            // Last command bit of a read: release data, keep clock high.
            if (byte_count_ff == 4'd0 && bit_count_ff == 3'd7 && is_read) begin
               drive_in      = 1'b0;
               bit_count_in  = '0;
               byte_count_in = '0;
               phase_in      = PH_RHIGH;
            end else begin
               clk_in = 1'b0;
               if (bit_count_ff == 3'd7) begin
                  bit_count_in  = '0;
                  byte_count_in = byte_inc;
                  phase_in      = (byte_inc > data_bytes) ? PH_STOP : PH_SET;
               end else begin
                  bit_count_in = bit_count_ff + 3'd1;
                  phase_in     = PH_SET;
               end
            end
         end
         PH_RHIGH: begin
            clk_in   = 1'b1;
            phase_in = PH_RLOW;
         end
         PH_RLOW: begin
            clk_in        = 1'b0;
            pend_valid_in = 1'b1;
            pend_pos_in   = PosWidth'({byte_count_ff, bit_count_ff});
            if (bit_count_ff == 3'd7) begin
               bit_count_in  = '0;
               byte_count_in = byte_inc;
               phase_in      = (byte_inc >= data_bytes) ? PH_STOP : PH_RHIGH;
            end else begin
               bit_count_in = bit_count_ff + 3'd1;
               phase_in     = PH_RHIGH;
            end
         end
         default: begin
            ce_in       = 1'b0;
            result.done = 1'b1;
            result.busy = 1'b1;
            if (is_read) begin
               result.read_bytes = 64'(rx_shift_in);
            end
            phase_in = PH_IDLE;
         end
      endcase

      result.chip_enable  = ce_in;
      result.serial_clock = clk_in;
      result.io_out       = io_in_next;
      result.io_drive     = drive_in;
   end

endmodule

`default_nettype wire

// File: hdl/three_wire_rtc_serial_master_core.sv
`default_nettype none

// Three-wire serial RTC master (chip enable, serial clock, bidirectional data,
// LSB first). Every req beat is one bit-timing tick and carries the sampled
// data pin; every tick yields exactly one rsp beat with the pin levels after
// that tick, busy, a done pulse on the stop tick and, on the stop tick of a
// read, the bytes read (zero otherwise). While idle, req_cmd starts a single
// read, single write, clock burst read (0xBF) or clock burst write (0xBE);
// commands arriving while busy are ignored. Throughput is one tick per clock
// when rsp is not back-pressured: a beat is captured in an input register, and
// when it steps, the link engine advances its state and the rsp register loads
// the result. Both stages advance together whenever the rsp register is empty
// or being drained, so back-pressure on rsp stalls the link state with no loss.
module three_wire_rtc_serial_master_core #(
   parameter int unsigned BURST_BYTES = trsm_pkg::BurstBytesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel: one tick per beat
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [7:0]  req_reg_address,
   input  wire logic [63:0] req_write_bytes,
   input  wire logic        req_io_in,
   // response channel: one result per tick
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_chip_enable,
   output      logic        rsp_serial_clock,
   output      logic        rsp_io_out,
   output      logic        rsp_io_drive,
   output      logic        rsp_busy_res,
   output      logic        rsp_done_res,
   output      logic [63:0] rsp_read_bytes
);
   import trsm_pkg::*;

   // input register
   logic            s1_valid_ff, s1_valid_in;
   logic [2:0]      s1_cmd_ff;
   logic [7:0]      s1_addr_ff;
   logic [63:0]     s1_wdata_ff;
   logic            s1_io_ff;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   tick_result_type rsp_ff;

   tick_result_type tick_result;
   logic            step;
   logic            req_beat;

   // The engine commits a tick when the captured beat can move into the
   // result register.
   assign step      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || step;
   assign req_beat  = req_valid && req_ready;

   assign s1_valid_in  = req_beat || (s1_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_cmd_ff   <= req_cmd;
         s1_addr_ff  <= req_reg_address;
         s1_wdata_ff <= req_write_bytes;
         s1_io_ff    <= req_io_in;
      end
      if (step) begin
         rsp_ff <= tick_result;
      end
   end

   trsm_engine #(
      .BURST_BYTES (BURST_BYTES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .cmd         (s1_cmd_ff),
      .reg_address (s1_addr_ff),
      .write_bytes (s1_wdata_ff),
      .io_in       (s1_io_ff),
      .result      (tick_result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chip_enable  = rsp_ff.chip_enable;
   assign rsp_serial_clock = rsp_ff.serial_clock;
   assign rsp_io_out       = rsp_ff.io_out;
   assign rsp_io_drive     = rsp_ff.io_drive;
   assign rsp_busy_res     = rsp_ff.busy;
   assign rsp_done_res     = rsp_ff.done;
   assign rsp_read_bytes   = rsp_ff.read_bytes;

   // An empty result register never holds off the request side.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("req_ready low with empty result register");

   // The stop tick always drops chip enable and reports busy.
   a_done_beat_pins: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.done) |-> (!rsp_ff.chip_enable && rsp_ff.busy))
      else $error("done beat with chip enable high or busy low");

   // Read data shows up on the done beat only.
   a_read_data_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.done) |-> (rsp_ff.read_bytes == 64'd0))
      else $error("read data outside a done beat");

   // A tick committed while the result register holds an untaken beat
   // would overwrite it.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !step)
      else $error("result register overwritten under back-pressure");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import trsm_pkg::*;

   // Run limits, in clock cycles. The slowest correct run is under 1k ticks,
   // each of which can sit behind a sender gap and a receiver stall, plus
   // one long hold-off. The watchdog sits far beyond that.
   localparam int unsigned CYCLE_LIMIT  = 200_000;
   localparam int unsigned LONG_HOLD    = 100;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned RANDOM_TICKS = 40;

   // Data pin level offered by the far end during an operation
   typedef enum {IO_LOW, IO_HIGH, IO_RANDOM} io_level_e;

   // Receiver stall behavior, chosen per segment
   typedef enum {RX_STEADY, RX_COIN, RX_SPARSE, RX_MASK} rx_mode_e;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [2:0]  req_cmd         = CMD_TICK;
   logic [7:0]  req_reg_address = '0;
   logic [63:0] req_write_bytes = '0;
   logic        req_io_in       = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic        rsp_chip_enable;
   logic        rsp_serial_clock;
   logic        rsp_io_out;
   logic        rsp_io_drive;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [63:0] rsp_read_bytes;

   three_wire_rtc_serial_master_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_reg_address  (req_reg_address),
      .req_write_bytes  (req_write_bytes),
      .req_io_in        (req_io_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_chip_enable  (rsp_chip_enable),
      .rsp_serial_clock (rsp_serial_clock),
      .rsp_io_out       (rsp_io_out),
      .rsp_io_drive     (rsp_io_drive),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_read_bytes   (rsp_read_bytes)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Link shadow: tracks the serial engine tick by tick. One call per
   // accepted req beat yields the rsp beat that tick must produce.
   // ------------------------------------------------------------------
   phase_type   lk_phase;
   logic [2:0]  lk_bit;
   logic [3:0]  lk_byte;      // 0 = command byte, then data bytes (reads count data from 0)
   logic [2:0]  lk_op;
   logic [63:0] lk_tx;
   logic [7:0]  lk_cmd_byte;
   logic [63:0] lk_rx;
   logic        pin_ce, pin_clk, pin_io, pin_drv;
   logic        smp_pending;  // a read bit is due on the next io sample
   logic [5:0]  smp_pos;

   tick_result_type tick_results_due[$];

   int unsigned ticks_sent;
   int unsigned fail_count;

   function automatic bit link_is_read();
      return lk_op == CMD_SREAD || lk_op == CMD_BREAD;
   endfunction

   function automatic int unsigned link_data_bytes();
      return (lk_op == CMD_BREAD || lk_op == CMD_BWRITE) ? BurstBytesDefault : 1;
   endfunction

   // the pin is read one tick after the clock fell
   function automatic void link_sample(logic io);
      if (smp_pending) begin
         if (io) lk_rx[smp_pos] = 1'b1;
         smp_pending = 1'b0;
      end
   endfunction

   function automatic void link_reset();
      lk_phase    = PH_IDLE;
      lk_bit      = '0;
      lk_byte     = '0;
      lk_op       = CMD_TICK;
      lk_tx       = '0;
      lk_cmd_byte = '0;
      lk_rx       = '0;
      pin_ce      = 1'b0;
      pin_clk     = 1'b0;
      pin_io      = 1'b0;
      pin_drv     = 1'b0;
      smp_pending = 1'b0;
      smp_pos     = '0;
   endfunction

   function automatic tick_result_type advance_link(logic [2:0] cmd, logic [7:0] addr,
                                                    logic [63:0] wdata, logic io);
      tick_result_type r;
      int unsigned     pos;
      logic            now_busy;
      logic            now_done;
      logic [63:0]     rbytes;
      now_busy = (lk_phase != PH_IDLE);
      now_done = 1'b0;
      rbytes   = '0;
      case (lk_phase)
         PH_IDLE: begin
            // only codes 1..4 start anything; 0 and 5..7 are plain ticks
            if (cmd >= CMD_SREAD && cmd <= CMD_BWRITE) begin
               lk_op = cmd;
               case (cmd)
                  CMD_SREAD:  lk_cmd_byte = addr | 8'h01;
                  CMD_SWRITE: lk_cmd_byte = addr & 8'hFE;
                  CMD_BREAD:  lk_cmd_byte = BURST_READ_CMD;
                  default:    lk_cmd_byte = BURST_WRITE_CMD;
               endcase
               lk_tx       = (cmd == CMD_SWRITE) ? {56'd0, wdata[7:0]} : wdata;
               lk_rx       = '0;
               lk_bit      = '0;
               lk_byte     = '0;
               smp_pending = 1'b0;
               pin_ce      = 1'b1;
               pin_clk     = 1'b0;
               pin_drv     = 1'b1;
               lk_phase    = PH_SET;
               now_busy    = 1'b1;
            end
         end
         PH_SET: begin
            if (lk_byte == 0) begin
               pin_io = lk_cmd_byte[lk_bit];
            end else begin
               pos    = (lk_byte - 1) * 8 + lk_bit;
               pin_io = lk_tx[pos[5:0]];
            end
            lk_phase = PH_HIGH;
         end
         PH_HIGH: begin
            pin_clk  = 1'b1;
            lk_phase = PH_LOW;
         end
         PH_LOW: begin
            // last command bit of a read: release data, leave clock high
            if (lk_byte == 0 && lk_bit == 3'd7 && link_is_read()) begin
               pin_drv  = 1'b0;
               lk_bit   = '0;
               lk_byte  = '0;
               lk_phase = PH_RHIGH;
            end else begin
               pin_clk = 1'b0;
               if (lk_bit == 3'd7) begin
                  lk_bit   = '0;
                  lk_byte  = lk_byte + 4'd1;
                  lk_phase = (lk_byte > link_data_bytes()) ? PH_STOP : PH_SET;
               end else begin
                  lk_bit   = lk_bit + 3'd1;
                  lk_phase = PH_SET;
               end
            end
         end
         PH_RHIGH: begin
            link_sample(io);
            pin_clk  = 1'b1;
            lk_phase = PH_RLOW;
         end
         PH_RLOW: begin
            pin_clk     = 1'b0;
            smp_pending = 1'b1;
            smp_pos     = 6'(lk_byte * 8 + lk_bit);
            if (lk_bit == 3'd7) begin
               lk_bit   = '0;
               lk_byte  = lk_byte + 4'd1;
               lk_phase = (lk_byte >= link_data_bytes()) ? PH_STOP : PH_RHIGH;
            end else begin
               lk_bit   = lk_bit + 3'd1;
               lk_phase = PH_RHIGH;
            end
         end
         default: begin
            // stop tick: last read sample lands here too
            link_sample(io);
            pin_ce   = 1'b0;
            now_done = 1'b1;
            now_busy = 1'b1;
            if (link_is_read()) rbytes = lk_rx;
            lk_phase = PH_IDLE;
         end
      endcase
      r.chip_enable  = pin_ce;
      r.serial_clock = pin_clk;
      r.io_out       = pin_io;
      r.io_drive     = pin_drv;
      r.busy         = now_busy;
      r.done         = now_done;
      r.read_bytes   = rbytes;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------
   int unsigned cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Receiver: segments of steady, coin-flip, sparse or masked ready,
   // plus a long hold-off on request from a test.
   // ------------------------------------------------------------------
   int unsigned hold_requests = 0;
   int unsigned hold_served   = 0;
   int unsigned hold_left     = 0;
   int unsigned seg_left      = 0;
   rx_mode_e    seg_mode      = RX_STEADY;
   logic [7:0]  seg_mask      = 8'hFF;

   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= LONG_HOLD;
         rsp_ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (seg_left == 0) begin
            seg_mode <= rx_mode_e'($urandom_range(0, 3));
            seg_left <= $urandom_range(4, 48);
            seg_mask <= 8'($urandom);
         end else begin
            seg_left <= seg_left - 1;
         end
         case (seg_mode)
            RX_STEADY: rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ready <= seg_mask[cycle_count[2:0]];
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Rsp checker: every accepted rsp beat against the oldest expectation
   // ------------------------------------------------------------------
   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      tick_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (tick_results_due.size() == 0) begin
            $error("rsp beat with no tick outstanding");
            fail_count++;
         end else begin
            want = tick_results_due.pop_front();
            check_field("chip_enable",  64'(want.chip_enable),  64'(rsp_chip_enable));
            check_field("serial_clock", 64'(want.serial_clock), 64'(rsp_serial_clock));
            check_field("io_out",       64'(want.io_out),       64'(rsp_io_out));
            check_field("io_drive",     64'(want.io_drive),     64'(rsp_io_drive));
            check_field("busy_res",     64'(want.busy),         64'(rsp_busy_res));
            check_field("done_res",     64'(want.done),         64'(rsp_done_res));
            check_field("read_bytes",   want.read_bytes,        rsp_read_bytes);
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender: bursts of beats with random gaps; now and then a long
   // burst with no gaps at all.
   // ------------------------------------------------------------------
   int unsigned burst_left    = 0;
   bit          valid_dropped = 1'b1;

   function automatic logic [63:0] rand_bytes();
      return {$urandom, $urandom};
   endfunction

   function automatic logic pick_io(io_level_e lvl);
      case (lvl)
         IO_LOW:  return 1'b0;
         IO_HIGH: return 1'b1;
         default: return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // One tick: hold the beat until accepted, then record its result.
   task automatic send_tick(input logic [2:0] cmd, input logic [7:0] addr,
                            input logic [63:0] wdata, input logic io);
      int unsigned gap;
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_reg_address <= addr;
      req_write_bytes <= wdata;
      req_io_in       <= io;
      valid_dropped    = 1'b0;
      do @(posedge clock); while (!req_ready);
      tick_results_due.push_back(advance_link(cmd, addr, wdata, io));
      ticks_sent++;
      // pacing: the lowering of valid lands in the accept step only
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 16);
         gap = $urandom_range(1, 5);
         req_valid    <= 1'b0;
         valid_dropped = 1'b1;
         repeat (gap) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   // Start an operation and tick it through to idle. While busy, the
   // ticks carry either quiet fields or random commands that must be
   // ignored.
   task automatic run_op(input logic [2:0] cmd, input logic [7:0] addr,
                         input logic [63:0] wdata, input io_level_e lvl,
                         input bit noise);
      send_tick(cmd, addr, wdata, pick_io(lvl));
      while (lk_phase != PH_IDLE) begin
         if (noise)
            send_tick(3'($urandom), 8'($urandom), rand_bytes(), pick_io(lvl));
         else
            send_tick(CMD_TICK, 8'h00, 64'd0, pick_io(lvl));
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Plain ticks and unused codes while idle: pins stay put, nothing starts
   task automatic test_idle_codes();
      send_tick(CMD_TICK, 8'hFF, '1, 1'b1);
      for (int c = int'(CMD_BWRITE) + 1; c < 8; c++)
         send_tick(3'(c), (c[0] ? 8'h00 : 8'hFF), (c[0] ? 64'd0 : '1), c[0]);
   endtask

   // Single read forces address bit 0 high; pin all-high and random data
   task automatic test_single_read();
      run_op(CMD_SREAD, 8'h00, 64'd0, IO_RANDOM, 1'b0);
      run_op(CMD_SREAD, 8'hFE, '1, IO_HIGH, 1'b0);
   endtask

   // Single write clears address bit 0 and sends only the low data byte
   task automatic test_single_write();
      run_op(CMD_SWRITE, 8'hFF, '1, IO_HIGH, 1'b0);
   endtask

   // Clock burst read ignores the address; random pin data
   task automatic test_burst_read();
      run_op(CMD_BREAD, 8'h55, rand_bytes(), IO_RANDOM, 1'b0);
   endtask

   task automatic test_burst_write();
      run_op(CMD_BWRITE, 8'hAA, rand_bytes(), IO_RANDOM, 1'b0);
   endtask

   // New commands arriving mid-operation must not disturb it
   task automatic test_busy_commands();
      run_op(CMD_SREAD, 8'($urandom), rand_bytes(), IO_RANDOM, 1'b1);
   endtask

   // Receiver holds off for a long stretch while ticks keep coming in
   task automatic test_rsp_backpressure();
      hold_requests++;
      run_op(CMD_SWRITE, 8'($urandom), rand_bytes(), IO_RANDOM, 1'b1);
   endtask

   // Mostly well-formed operations with random content, some idle noise
   task automatic test_random_traffic();
      int unsigned stop_at;
      int unsigned c;
      int unsigned pick;
      logic [2:0]  op;
      stop_at = ticks_sent + RANDOM_TICKS;
      while (ticks_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) begin
            c  = $urandom_range(0, 3);
            op = (c == 0) ? CMD_TICK : CMD_BWRITE + 3'(c);
            send_tick(op, 8'($urandom), rand_bytes(), 1'($urandom_range(0, 1)));
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 4)       op = CMD_SREAD;
            else if (pick < 8)  op = CMD_SWRITE;
            else if (pick == 8) op = CMD_BREAD;
            else                op = CMD_BWRITE;
            run_op(op, 8'($urandom), rand_bytes(), IO_RANDOM, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      link_reset();
      ticks_sent = 0;
      fail_count = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_idle_codes();
      test_single_read();
      test_single_write();
      test_burst_read();
      test_burst_write();
      test_busy_commands();
      test_rsp_backpressure();
      test_random_traffic();

      if (!valid_dropped) req_valid <= 1'b0;
      while (tick_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
